// File: src/rcbr_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Rotated crop resampler package
// Shared constants, controller state type and command and status structs.
// ----------------------------------------------------------------------------
package rcbr_pkg;

  localparam int MAX_DIM_DEF   = 256;
  localparam int FRAC_BITS_DEF = 8;
  localparam int TRIG_BITS     = 14;
  localparam int COMP_W        = 16;
  localparam int PIX_W         = 48;

  localparam logic [2:0] REG_SRC_W  = 3'd0;
  localparam logic [2:0] REG_SRC_H  = 3'd1;
  localparam logic [2:0] REG_OUT_W  = 3'd2;
  localparam logic [2:0] REG_OUT_H  = 3'd3;
  localparam logic [2:0] REG_COS    = 3'd4;
  localparam logic [2:0] REG_SIN    = 3'd5;
  localparam logic [2:0] REG_DX     = 3'd6;
  localparam logic [2:0] REG_DY     = 3'd7;

  localparam logic ACT_WRITE  = 1'b0;
  localparam logic ACT_SAMPLE = 1'b1;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_ROT,
    ST_ADD,
    ST_IDX,
    ST_RD00,
    ST_RD10,
    ST_RD01,
    ST_RD11,
    ST_BLX,
    ST_BLY,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic       load;     // capture the input beat
    logic       wr_pix;   // write the captured pixel to the image memory
    logic       rot;      // form the rotated products
    logic       add;      // sum products, form source coordinates
    logic       idx;      // clamp indices and fractions
    logic [1:0] rd_sel;   // which neighbor to address
    logic       rd_en;    // issue a memory read
    logic [1:0] cap_sel;  // which neighbor to capture
    logic       cap_en;   // capture read data
    logic       blx;      // horizontal blends
    logic       bly;      // vertical blend and output register load
  } cmd_t;

  typedef struct packed {
    logic is_sample;
    logic in_bounds;
  } stat_t;

endpackage

// File: src/rotated_crop_bilinear_resampler_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Rotated crop bilinear resampler, top level
// Holds a normal map and resamples it through a rotated crop window.
// ----------------------------------------------------------------------------
// Usage:
//   Input beats on in_* carry either a source pixel write (action low) or a
//   sample request (action high). A write is committed to the image memory
//   in the cycle after it is taken if its column and row lie inside the
//   source size; it produces no output beat. A sample rotates the output
//   coordinate about the source center, reads the four neighbors from the
//   single-port image memory one after another, blends them and presents
//   one beat on out_*. The block takes one item at a time: a sample holds
//   in_tready low until it has loaded its result, while a write leaves the
//   block idle and ready for another beat.
//   When the receiver holds out_tready low, the result stays in the output
//   register. The block keeps taking beats; a following sample waits with
//   in_tready low until the held beat is taken and then loads its result.
//   Reset (rst_n low, synchronous) returns the controller to idle and the
//   configuration registers to their defaults. The image memory is not
//   cleared; pixels must be written before they are sampled.
//   Configuration writes are taken whenever cfg_we is high and should be
//   issued only while the block is idle.
// ----------------------------------------------------------------------------
module rotated_crop_bilinear_resampler_top #(
  parameter int FRAC_BITS = rcbr_pkg::FRAC_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // [7:0] pix_col, [15:8] pix_row, [31:16] comp_x, [47:32] comp_y,
  // [63:48] comp_z
  input  logic [63:0] in_tdata,
  // [0] action
  input  logic        in_tuser,
  output logic        out_tvalid,
  input  logic        out_tready,
  // [15:0] res_x, [31:16] res_y, [47:32] res_z
  output logic [47:0] out_tdata,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [17:0] cfg_data
);

  logic [8:0]         src_w_r, src_h_r, out_w_r, out_h_r;
  logic signed [15:0] cos_r, sin_r;
  logic signed [17:0] dx_r, dy_r;

  // Crop sizes are stored but do not enter the math.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      src_w_r <= 9'd256; src_h_r <= 9'd256;
      out_w_r <= 9'd256; out_h_r <= 9'd256;
      cos_r   <= 16'sd16384; sin_r <= '0;
      dx_r    <= '0; dy_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        rcbr_pkg::REG_SRC_W: src_w_r <= cfg_data[8:0];
        rcbr_pkg::REG_SRC_H: src_h_r <= cfg_data[8:0];
        rcbr_pkg::REG_OUT_W: out_w_r <= cfg_data[8:0];
        rcbr_pkg::REG_OUT_H: out_h_r <= cfg_data[8:0];
        rcbr_pkg::REG_COS:   cos_r   <= cfg_data[15:0];
        rcbr_pkg::REG_SIN:   sin_r   <= cfg_data[15:0];
        rcbr_pkg::REG_DX:    dx_r    <= cfg_data;
        default:             dy_r    <= cfg_data;
      endcase
    end
  end

  logic            out_valid_r;
  logic            in_fire;
  rcbr_pkg::cmd_t  cmd;
  rcbr_pkg::stat_t stat;
  logic            crop_seen;

  assign in_fire   = in_tvalid && in_tready;
  assign crop_seen = |{out_w_r, out_h_r};

  rcbr_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_fire  (in_fire),
    .stat     (stat),
    .out_busy (out_valid_r && !out_tready && crop_seen | out_valid_r && !out_tready),
    .in_ready (in_tready),
    .cmd      (cmd)
  );

  rcbr_dp #(.FRAC_BITS(FRAC_BITS)) u_dp (
    .clk       (clk),
    .cmd       (cmd),
    .in_action (in_tuser),
    .in_col    (in_tdata[7:0]),
    .in_row    (in_tdata[15:8]),
    .in_comp   (in_tdata[63:16]),
    .src_w     (src_w_r),
    .src_h     (src_h_r),
    .cos_a     (cos_r),
    .sin_a     (sin_r),
    .start_dx  (dx_r),
    .start_dy  (dy_r),
    .stat      (stat),
    .res       (out_tdata)
  );

  // Output valid rises when the blended value is loaded.
  always_ff @(posedge clk) begin
    if (!rst_n) out_valid_r <= 1'b0;
    else if (cmd.bly) out_valid_r <= 1'b1;
    else if (out_tready) out_valid_r <= 1'b0;
  end

  assign out_tvalid = out_valid_r;

endmodule

// File: src/rcbr_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Generic single-port RAM
// One write or one read per cycle, registered read data.
// ----------------------------------------------------------------------------
module rcbr_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 65536
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[addr] <= wdata;
    end else if (re) begin
      rdata_r <= mem_r[addr];
    end
  end

  assign rdata = rdata_r;

endmodule

// File: src/rcbr_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Resampler controller
// Sequences pixel writes and the steps of one sample.
// ----------------------------------------------------------------------------
module rcbr_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_fire,
  input  rcbr_pkg::stat_t      stat,
  input  logic                 out_busy,
  output logic                 in_ready,
  output rcbr_pkg::cmd_t       cmd
);

  rcbr_pkg::state_t state_r, state_nxt;
  logic             wr_pend_r, wr_pend_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= rcbr_pkg::ST_IDLE;
      wr_pend_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      wr_pend_r <= wr_pend_nxt;
    end
  end

  // A captured write is committed in the cycle after the beat if it lies inside the source size.
  always_comb begin
    state_nxt   = state_r;
    wr_pend_nxt = 1'b0;
    unique case (state_r)
      rcbr_pkg::ST_IDLE: begin
        if (in_fire) begin
          if (stat.is_sample) state_nxt = rcbr_pkg::ST_ROT;
          else wr_pend_nxt = 1'b1;
        end
      end
      rcbr_pkg::ST_ROT:  state_nxt = rcbr_pkg::ST_ADD;
      rcbr_pkg::ST_ADD:  state_nxt = rcbr_pkg::ST_IDX;
      rcbr_pkg::ST_IDX:  state_nxt = rcbr_pkg::ST_RD00;
      rcbr_pkg::ST_RD00: state_nxt = rcbr_pkg::ST_RD10;
      rcbr_pkg::ST_RD10: state_nxt = rcbr_pkg::ST_RD01;
      rcbr_pkg::ST_RD01: state_nxt = rcbr_pkg::ST_RD11;
      rcbr_pkg::ST_RD11: state_nxt = rcbr_pkg::ST_BLX;
      rcbr_pkg::ST_BLX:  state_nxt = rcbr_pkg::ST_BLY;
      rcbr_pkg::ST_BLY:  state_nxt = rcbr_pkg::ST_OUT;
      rcbr_pkg::ST_OUT:  if (!out_busy) state_nxt = rcbr_pkg::ST_IDLE;
      default:           state_nxt = rcbr_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd        = '0;
    cmd.wr_pix = wr_pend_r && stat.in_bounds;
    in_ready   = 1'b0;
    unique case (state_r)
      rcbr_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_fire;
      end
      rcbr_pkg::ST_ROT:  cmd.rot = 1'b1;
      rcbr_pkg::ST_ADD:  cmd.add = 1'b1;
      rcbr_pkg::ST_IDX:  cmd.idx = 1'b1;
      rcbr_pkg::ST_RD00: begin
        cmd.rd_en = 1'b1; cmd.rd_sel = 2'd0;
      end
      rcbr_pkg::ST_RD10: begin
        cmd.rd_en = 1'b1; cmd.rd_sel = 2'd1;
        cmd.cap_en = 1'b1; cmd.cap_sel = 2'd0;
      end
      rcbr_pkg::ST_RD01: begin
        cmd.rd_en = 1'b1; cmd.rd_sel = 2'd2;
        cmd.cap_en = 1'b1; cmd.cap_sel = 2'd1;
      end
      rcbr_pkg::ST_RD11: begin
        cmd.rd_en = 1'b1; cmd.rd_sel = 2'd3;
        cmd.cap_en = 1'b1; cmd.cap_sel = 2'd2;
      end
      rcbr_pkg::ST_BLX: begin
        cmd.cap_en = 1'b1; cmd.cap_sel = 2'd3;
      end
      rcbr_pkg::ST_BLY:  cmd.blx = 1'b1;
      rcbr_pkg::ST_OUT:  cmd.bly = !out_busy;
      default: ;
    endcase
  end

endmodule

// File: src/rcbr_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Resampler datapath
// Coordinate rotation, neighbor addressing, image memory and blending.
// ----------------------------------------------------------------------------
module rcbr_dp #(
  parameter int FRAC_BITS = rcbr_pkg::FRAC_BITS_DEF
) (
  input  logic              clk,
  input  rcbr_pkg::cmd_t    cmd,
  input  logic              in_action,
  input  logic [7:0]        in_col,
  input  logic [7:0]        in_row,
  input  logic [47:0]       in_comp,
  input  logic [8:0]        src_w,
  input  logic [8:0]        src_h,
  input  logic signed [15:0] cos_a,
  input  logic signed [15:0] sin_a,
  input  logic signed [17:0] start_dx,
  input  logic signed [17:0] start_dy,
  output rcbr_pkg::stat_t   stat,
  output logic [47:0]       res
);

  localparam int MAX_DIM = rcbr_pkg::MAX_DIM_DEF;
  localparam int AW    = $clog2(MAX_DIM);
  localparam int DW    = AW + 1;
  localparam int F     = FRAC_BITS;
  localparam int CW    = 26;               // dx, dy width
  localparam int PW    = CW + 17;          // product width
  localparam int SW    = PW - rcbr_pkg::TRIG_BITS + 2;
  localparam int FW    = F + 6;            // clamped fraction width
  localparam int BW    = 16 + F + FW + 3;  // blend width
  localparam int PDW   = 17 + FW;          // neighbor difference times fraction
  localparam int CDW   = PDW + 2;          // difference of the two row blends
  localparam int NW    = CDW + FW + 2;

  logic [7:0]       col_r, row_r;
  logic [47:0]      comp_r;
  logic [DW-1:0]    w_eff, h_eff;

  // Size registers of zero act as one, above MAX_DIM as MAX_DIM.
  always_comb begin
    w_eff = (src_w == 9'd0) ? DW'(1) : ((32'(src_w) > MAX_DIM) ? DW'(MAX_DIM) : DW'(src_w));
    h_eff = (src_h == 9'd0) ? DW'(1) : ((32'(src_h) > MAX_DIM) ? DW'(MAX_DIM) : DW'(src_h));
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      col_r  <= in_col;
      row_r  <= in_row;
      comp_r <= in_comp;
    end
  end

  assign stat.is_sample = in_action;
  assign stat.in_bounds = ({1'b0, col_r} < 9'(w_eff)) && ({1'b0, row_r} < 9'(h_eff));

  // Rotation products.
  logic signed [CW-1:0] dx, dy;
  logic signed [PW-1:0] pxc_r, pys_r, pyc_r, pxs_r;
  assign dx = $signed(CW'({col_r, F'(0)})) + CW'(start_dx);
  assign dy = $signed(CW'({row_r, F'(0)})) + CW'(start_dy);

  always_ff @(posedge clk) begin
    if (cmd.rot) begin
      pxc_r <= PW'(dx * cos_a);
      pys_r <= PW'(dy * sin_a);
      pyc_r <= PW'(dy * cos_a);
      pxs_r <= PW'(dx * sin_a);
    end
  end

  logic signed [PW:0]   rx, ry;
  logic signed [SW-1:0] sx_r, sy_r;
  assign rx = (PW+1)'(pxc_r) + (PW+1)'(pys_r);
  assign ry = (PW+1)'(pyc_r) - (PW+1)'(pxs_r);

  always_ff @(posedge clk) begin
    if (cmd.add) begin
      sx_r <= SW'(rx >>> rcbr_pkg::TRIG_BITS) + SW'({w_eff, (F-1)'(0)});
      sy_r <= SW'(ry >>> rcbr_pkg::TRIG_BITS) + SW'({h_eff, (F-1)'(0)});
    end
  end

  // Clamp indices and fractions.
  logic signed [SW-F-1:0] fx_i, fy_i;
  logic [AW-1:0] x0, y0, x1, y1;
  logic [AW-1:0] x0_r, y0_r, x1_r, y1_r;
  logic signed [SW:0] fxw, fyw;
  logic signed [FW-1:0] fx_r, fy_r;
  localparam logic signed [FW-1:0] FLIM = FW'(1) <<< (F + 4);

  assign fx_i = sx_r[SW-1:F];
  assign fy_i = sy_r[SW-1:F];

  always_comb begin
    if (fx_i < 0) x0 = '0;
    else if (fx_i > $signed((SW-F)'(w_eff) - (SW-F)'(1))) x0 = AW'(w_eff - DW'(1));
    else x0 = AW'(fx_i);
    if (fy_i < 0) y0 = '0;
    else if (fy_i > $signed((SW-F)'(h_eff) - (SW-F)'(1))) y0 = AW'(h_eff - DW'(1));
    else y0 = AW'(fy_i);
    x1 = (DW'(x0) + DW'(1) < w_eff) ? x0 + AW'(1) : x0;
    y1 = (DW'(y0) + DW'(1) < h_eff) ? y0 + AW'(1) : y0;
    fxw = (SW+1)'(sx_r) - (SW+1)'({x0, F'(0)});
    fyw = (SW+1)'(sy_r) - (SW+1)'({y0, F'(0)});
  end

  always_ff @(posedge clk) begin
    if (cmd.idx) begin
      x0_r <= x0; y0_r <= y0; x1_r <= x1; y1_r <= y1;
      fx_r <= (fxw > (SW+1)'(FLIM)) ? FLIM : ((fxw < -(SW+1)'(FLIM)) ? -FLIM : FW'(fxw));
      fy_r <= (fyw > (SW+1)'(FLIM)) ? FLIM : ((fyw < -(SW+1)'(FLIM)) ? -FLIM : FW'(fyw));
    end
  end

  // Image memory, row-major.
  logic [2*AW-1:0] addr;
  logic [47:0]     rdata;
  always_comb begin
    if (cmd.wr_pix) addr = {row_r[AW-1:0], col_r[AW-1:0]};
    else begin
      case (cmd.rd_sel)
        2'd0:    addr = {y0_r, x0_r};
        2'd1:    addr = {y0_r, x1_r};
        2'd2:    addr = {y1_r, x0_r};
        default: addr = {y1_r, x1_r};
      endcase
    end
  end

  rcbr_ram #(.WIDTH(rcbr_pkg::PIX_W), .DEPTH(MAX_DIM * MAX_DIM)) u_ram (
    .clk   (clk),
    .we    (cmd.wr_pix),
    .re    (cmd.rd_en),
    .addr  (addr),
    .wdata (comp_r),
    .rdata (rdata)
  );

  logic [47:0] nb_r [4];
  always_ff @(posedge clk) begin
    if (cmd.cap_en) nb_r[cmd.cap_sel] <= rdata;
  end

  // Blends, one lane per component.
  logic signed [BW-1:0] c0_r [3];
  logic signed [BW-1:0] c1_r [3];
  logic [47:0]          res_r;

  for (genvar k = 0; k < 3; k++) begin : g_lane
    logic signed [BW-1:0]     a00, a10, a01, a11, c0, c1;
    logic signed [16:0]       d0, d1;
    logic signed [PDW-1:0]    p0, p1;
    logic signed [CDW-1:0]    cd;
    logic signed [CDW+FW-1:0] q;
    logic signed [NW-1:0]     n, r;
    logic signed [15:0]       sat;
    assign a00 = BW'($signed(nb_r[0][16*k +: 16]));
    assign a10 = BW'($signed(nb_r[1][16*k +: 16]));
    assign a01 = BW'($signed(nb_r[2][16*k +: 16]));
    assign a11 = BW'($signed(nb_r[3][16*k +: 16]));
    assign d0  = 17'(a10) - 17'(a00);
    assign d1  = 17'(a11) - 17'(a01);
    assign p0  = d0 * fx_r;
    assign p1  = d1 * fx_r;
    assign c0  = (a00 <<< F) + BW'(p0);
    assign c1  = (a01 <<< F) + BW'(p1);
    assign cd  = CDW'(c1_r[k]) - CDW'(c0_r[k]);
    assign q   = cd * fy_r;
    assign n   = (NW'(c0_r[k]) <<< F) + NW'(q) + (NW'(1) <<< (2*F - 1));
    assign r   = n >>> (2*F);
    assign sat = (r > NW'(32767)) ? 16'sh7fff : ((r < -NW'(32768)) ? 16'sh8000 : 16'(r));
    always_ff @(posedge clk) begin
      if (cmd.blx) begin
        c0_r[k] <= c0;
        c1_r[k] <= c1;
      end
      if (cmd.bly) res_r[16*k +: 16] <= sat;
    end
  end

  assign res = res_r;

endmodule

// File: src/rcbr_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Resampler port checker
// Port-level properties of the resampler, bound to the top level.
// ----------------------------------------------------------------------------
module rcbr_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic        in_tuser,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [47:0] out_tdata
);

  // A stalled result keeps its data.
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed while stalled");

  // A write beat taken while no result is pending raises no result beat.
  a_write_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && !in_tuser && !out_tvalid |=> !out_tvalid)
    else $error("write produced a result");

  // A sample beat that is taken lowers in_tready, as the block is busy with it.
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && in_tuser |=> !in_tready)
    else $error("ready during sample");

endmodule

bind rotated_crop_bilinear_resampler_top rcbr_checker u_rcbr_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .in_tuser   (in_tuser),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
